FILE: rtl/mptc_pkg.sv
// Shared types and constants for the MIDI parser with time code.
package mptc_pkg;

  localparam logic [2:0] MODE_NORMAL    = 3'd0;
  localparam logic [2:0] MODE_SYSEX     = 3'd1;
  localparam logic [2:0] MODE_QF        = 3'd2;
  localparam logic [2:0] MODE_FM        = 3'd3;
  localparam logic [2:0] MODE_MTC_SYSEX = 3'd4;
  localparam logic [2:0] MODE_SYS_SYSEX = 3'd5;

  localparam logic [1:0] LOCK_INVALID = 2'd0;
  localparam logic [1:0] LOCK_VALID   = 2'd1;

  localparam logic [3:0] KIND_REALTIME = 4'd0;
  localparam logic [3:0] KIND_RAW      = 4'd1;
  localparam logic [3:0] KIND_SYSEX    = 4'd2;
  localparam logic [3:0] KIND_NOTE     = 4'd3;
  localparam logic [3:0] KIND_POLY     = 4'd4;
  localparam logic [3:0] KIND_CONTROL  = 4'd5;
  localparam logic [3:0] KIND_BEND     = 4'd6;
  localparam logic [3:0] KIND_CTOUCH   = 4'd7;
  localparam logic [3:0] KIND_PROGRAM  = 4'd8;
  localparam logic [3:0] KIND_TIMECODE = 4'd9;

  localparam logic [7:0] BYTE_SYSEX = 8'hF0;
  localparam logic [7:0] BYTE_QF    = 8'hF1;
  localparam logic [7:0] BYTE_EOX   = 8'hF7;
  localparam logic [7:0] BYTE_RT    = 8'hF8;
  localparam logic [7:0] BYTE_NONRT = 8'h7F;
  localparam logic [7:0] BYTE_ONE   = 8'h01;

  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  channel;
    logic [7:0]  data_first;
    logic [6:0]  data_second;
    logic [1:0]  rate;
    logic [4:0]  hours;
    logic [7:0]  minutes;
    logic [7:0]  seconds;
    logic [7:0]  frames;
    logic [26:0] ms;
    logic        back;
    logic        last;
  } result_t;

endpackage

FILE: rtl/mptc_time.sv
// Bit-serial time code to milliseconds converter.
module mptc_time (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  rate,
  input  logic [4:0]  hours,
  input  logic [7:0]  minutes,
  input  logic [7:0]  seconds,
  input  logic [7:0]  frames,
  input  logic [3:0]  comp,
  output logic        done,
  output logic [26:0] ms
);
  // phase 0: secs = (h*60+m)*60+s, then *1000, shift-add one bit a cycle
  // phase 1: restoring divide of (frames+comp)*1000 by fps, one bit a cycle
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]  ph_r, ph_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [16:0] secs_r, secs_nxt;
  logic [26:0] acc_r, acc_nxt;
  logic [18:0] dvd_r, dvd_nxt;
  logic [4:0]  rem_r, rem_nxt;
  logic [13:0] quo_r, quo_nxt;
  logic [4:0]  fps_r, fps_nxt;
  logic [5:0]  trial;
  logic [16:0] secs_calc;
  logic [8:0]  fsum;

  localparam logic [9:0] K1000 = 10'd1000;

  assign secs_calc = 17'(({12'd0, hours} * 17'd60 + {9'd0, minutes}) * 17'd60)
                     + {9'd0, seconds};
  assign fsum  = {1'b0, frames} + {5'd0, comp};
  assign trial = {rem_r, dvd_r[18]} - {1'b0, fps_r};

  always_comb begin
    ph_nxt = ph_r; cnt_nxt = cnt_r; secs_nxt = secs_r; acc_nxt = acc_r;
    dvd_nxt = dvd_r; rem_nxt = rem_r; quo_nxt = quo_r; fps_nxt = fps_r;
    unique case (ph_r)
      PH_IDLE: if (start) begin
        ph_nxt = PH_MUL; cnt_nxt = 5'd0; secs_nxt = secs_calc; acc_nxt = '0;
        dvd_nxt = {10'd0, fsum} * {9'd0, K1000}; rem_nxt = '0; quo_nxt = '0;
        fps_nxt = (rate == 2'd0) ? 5'd24 : ((rate == 2'd1) ? 5'd25 : 5'd30);
      end
      PH_MUL: begin
        if (K1000[cnt_r[3:0]]) acc_nxt = acc_r + (27'(secs_r) << cnt_r[3:0]);
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd9) begin ph_nxt = PH_DIV; cnt_nxt = '0; end
      end
      PH_DIV: begin
        dvd_nxt = {dvd_r[17:0], 1'b0};
        if (!trial[5]) begin
          rem_nxt = trial[4:0]; quo_nxt = {quo_r[12:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[3:0], dvd_r[18]}; quo_nxt = {quo_r[12:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd18) ph_nxt = PH_DONE;
      end
      PH_DONE: ph_nxt = PH_IDLE;
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ph_r <= PH_IDLE;
    else ph_r <= ph_nxt;
    cnt_r <= cnt_nxt; secs_r <= secs_nxt; acc_r <= acc_nxt; dvd_r <= dvd_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; fps_r <= fps_nxt;
  end

  assign done = (ph_r == PH_DONE);
  assign ms   = acc_r + {13'd0, quo_r};
endmodule

FILE: rtl/midi_parser_with_timecode_top.sv
// MIDI byte parser with running status and MIDI time code, top level.
// Usage:
//  - Input channel in_valid/in_ready carries one MIDI byte per beat.
//  - Output channel out_valid/out_ready carries one result per beat; a byte
//    yields one to three results, the final one flagged by out_last_of_run.
//  - cfg_we/cfg_wdata load frame compensation (reset value 2); write only
//    while the block is idle.
// Data flow and throughput:
//  - A byte is decoded in the cycle it is accepted and its results queue in
//    a small result buffer; each result then takes one output beat.
//  - A byte that completes a time code starts the serial converter, which
//    works one bit per cycle: 10 shift-add steps for the *1000, then 19
//    divide steps for the frame fraction.
//  - Bytes without time code go straight to draining, one beat per result.
//  - One byte is in flight at a time; in_ready returns once all of its
//    results have been taken.
// Reset: synchronous active-low rst_n returns the parser to normal mode,
// running status to note off on channel one, time code fields to zero.
// Stall: while out_ready is low the current result holds and nothing new
// is accepted.
module midi_parser_with_timecode_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_midi_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_kind,
  output logic [4:0]  out_channel,
  output logic [7:0]  out_data_first,
  output logic [6:0]  out_data_second,
  output logic [1:0]  out_frame_rate_code,
  output logic [4:0]  out_tc_hours,
  output logic [7:0]  out_tc_minutes,
  output logic [7:0]  out_tc_seconds,
  output logic [7:0]  out_tc_frames,
  output logic [26:0] out_time_ms,
  output logic        out_time_went_back,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);
  // control states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TIME = 2'd1;  // waiting for converter
  localparam logic [1:0] ST_OUT  = 2'd2;  // draining results

  logic [1:0] st_r, st_nxt;
  logic [3:0] comp_r;
  logic [2:0] mode_r, mode_nxt;
  logic [2:0] rcmd_r, rcmd_nxt;
  logic [3:0] rchan_r, rchan_nxt;
  logic [6:0] held_r, held_nxt;
  logic       have_r, have_nxt;
  logic [2:0] ffc_r, ffc_nxt;
  logic [1:0] rate_r, rate_nxt;
  logic [4:0] hours_r, hours_nxt;
  logic [7:0] min_r, min_nxt;
  logic [7:0] sec_r, sec_nxt;
  logic [7:0] frm_r, frm_nxt;
  logic [26:0] prev_r;
  logic [1:0] lock_r, lock_nxt;

  // result buffer: up to 3 entries; time code slot filled by converter
  mptc_pkg::result_t buf_r [3];
  mptc_pkg::result_t buf_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;   // results in this run
  logic [1:0] pos_r, pos_nxt;   // next to send
  logic [1:0] tcs_r, tcs_nxt;   // slot of time code result
  // time code snapshot (quarter frame piece 0 emits before its update)
  logic [1:0] sr_r, sr_nxt;
  logic [4:0] sh_r, sh_nxt;
  logic [7:0] sm_r, sm_nxt, ss_r, ss_nxt, sf_r, sf_nxt;

  logic        tc_start, tc_done;
  logic [26:0] tc_ms;
  logic [7:0]  b;
  logic        accept;

  assign b      = in_midi_byte;
  assign accept = in_valid && in_ready;
  assign in_ready = (st_r == ST_IDLE);

  mptc_time u_time (
    .clk(clk), .rst_n(rst_n), .start(tc_start),
    .rate(sr_nxt), .hours(sh_nxt), .minutes(sm_nxt), .seconds(ss_nxt),
    .frames(sf_nxt), .comp(comp_r), .done(tc_done), .ms(tc_ms)
  );

  always_comb begin
    mptc_pkg::result_t r;
    logic [3:0] k;
    logic       two;
    logic       tc;
    st_nxt = st_r; mode_nxt = mode_r; rcmd_nxt = rcmd_r; rchan_nxt = rchan_r;
    held_nxt = held_r; have_nxt = have_r; ffc_nxt = ffc_r; rate_nxt = rate_r;
    hours_nxt = hours_r; min_nxt = min_r; sec_nxt = sec_r; frm_nxt = frm_r;
    lock_nxt = lock_r; cnt_nxt = cnt_r; pos_nxt = pos_r; tcs_nxt = tcs_r;
    sr_nxt = sr_r; sh_nxt = sh_r; sm_nxt = sm_r; ss_nxt = ss_r; sf_nxt = sf_r;
    buf_nxt = buf_r;
    tc_start = 1'b0; tc = 1'b0; k = '0; two = 1'b1;
    r = '0;
    unique case (st_r)
      ST_IDLE: if (accept) begin
        pos_nxt = '0;
        for (int i = 0; i < 3; i++) buf_nxt[i] = '0;
        if (b >= mptc_pkg::BYTE_RT) begin
          r.kind = mptc_pkg::KIND_REALTIME; r.data_first = b;
          buf_nxt[0] = r; cnt_nxt = 2'd1;
        end else begin
          r.kind = mptc_pkg::KIND_RAW; r.data_first = b;
          buf_nxt[0] = r; cnt_nxt = 2'd1;
          r = '0; r.kind = mptc_pkg::KIND_SYSEX; r.data_first = b;
          case (mode_r)
            mptc_pkg::MODE_FM: begin
              buf_nxt[1] = r; cnt_nxt = 2'd2;
              case (ffc_r)
                3'd0: begin rate_nxt = b[6:5]; hours_nxt = b[4:0]; end
                3'd1: min_nxt = b;
                3'd2: sec_nxt = b;
                3'd3: frm_nxt = b;
                default: ;
              endcase
              if (ffc_r < 3'd4) ffc_nxt = ffc_r + 3'd1;
              if (b == mptc_pkg::BYTE_EOX) begin
                lock_nxt = mptc_pkg::LOCK_VALID; tc = 1'b1;
                mode_nxt = mptc_pkg::MODE_NORMAL;
                sr_nxt = rate_nxt; sh_nxt = hours_nxt; sm_nxt = min_nxt;
                ss_nxt = sec_nxt; sf_nxt = frm_nxt;
              end
            end
            mptc_pkg::MODE_MTC_SYSEX: begin
              buf_nxt[1] = r; cnt_nxt = 2'd2;
              if (b == mptc_pkg::BYTE_ONE) begin
                mode_nxt = mptc_pkg::MODE_FM; ffc_nxt = '0;
              end else if (b == mptc_pkg::BYTE_EOX) mode_nxt = mptc_pkg::MODE_NORMAL;
            end
            mptc_pkg::MODE_SYS_SYSEX: begin
              buf_nxt[1] = r; cnt_nxt = 2'd2;
              if (b == mptc_pkg::BYTE_ONE) mode_nxt = mptc_pkg::MODE_MTC_SYSEX;
              else if (b == mptc_pkg::BYTE_EOX) mode_nxt = mptc_pkg::MODE_NORMAL;
            end
            mptc_pkg::MODE_SYSEX: begin
              buf_nxt[1] = r; cnt_nxt = 2'd2;
              if (b == mptc_pkg::BYTE_EOX) mode_nxt = mptc_pkg::MODE_NORMAL;
              else if (b == mptc_pkg::BYTE_NONRT) mode_nxt = mptc_pkg::MODE_SYS_SYSEX;
            end
            mptc_pkg::MODE_QF: begin
              mode_nxt = mptc_pkg::MODE_NORMAL;
              case (b[7:4])
                4'd0: begin
                  lock_nxt = mptc_pkg::LOCK_VALID; tc = 1'b1;
                  sr_nxt = rate_r; sh_nxt = hours_r; sm_nxt = min_r;
                  ss_nxt = sec_r; sf_nxt = frm_r;
                  frm_nxt = {frm_r[7:4], b[3:0]};
                end
                4'd1: frm_nxt = {b[3:0], frm_r[3:0]};
                4'd2: sec_nxt = {sec_r[7:4], b[3:0]};
                4'd3: sec_nxt = {b[3:0], sec_r[3:0]};
                4'd4: min_nxt = {min_r[7:4], b[3:0]};
                4'd5: min_nxt = {b[3:0], min_r[3:0]};
                4'd6: hours_nxt = {hours_r[4], b[3:0]};
                4'd7: begin hours_nxt = {b[0], hours_r[3:0]}; rate_nxt = b[2:1]; end
                default: ;
              endcase
            end
            default: begin
              if (b == mptc_pkg::BYTE_QF) mode_nxt = mptc_pkg::MODE_QF;
              else if (b == mptc_pkg::BYTE_SYSEX) begin
                mode_nxt = mptc_pkg::MODE_SYSEX; buf_nxt[1] = r; cnt_nxt = 2'd2;
              end else if (b[7]) begin
                rcmd_nxt = b[6:4]; rchan_nxt = b[3:0]; have_nxt = 1'b0;
              end else if (rcmd_r != 3'd7) begin
                case (rcmd_r)
                  3'd2: k = mptc_pkg::KIND_POLY;
                  3'd3: k = mptc_pkg::KIND_CONTROL;
                  3'd4: begin k = mptc_pkg::KIND_PROGRAM; two = 1'b0; end
                  3'd5: begin k = mptc_pkg::KIND_CTOUCH; two = 1'b0; end
                  3'd6: k = mptc_pkg::KIND_BEND;
                  default: k = mptc_pkg::KIND_NOTE;
                endcase
                if (two && !have_r) begin
                  held_nxt = b[6:0]; have_nxt = 1'b1;
                end else begin
                  r = '0; r.kind = k; r.channel = {1'b0, rchan_r} + 5'd1;
                  if (two) begin
                    r.data_first = {1'b0, held_r};
                    r.data_second = (rcmd_r == 3'd0) ? 7'd0 : b[6:0];
                  end else r.data_first = b;
                  buf_nxt[1] = r; cnt_nxt = 2'd2; have_nxt = 1'b0;
                end
              end
            end
          endcase
        end
        if (tc) begin
          tcs_nxt = cnt_nxt; cnt_nxt = cnt_nxt + 2'd1;
          tc_start = 1'b1; st_nxt = ST_TIME;
        end else st_nxt = ST_OUT;
      end
      ST_TIME: if (tc_done) begin
        r = '0; r.kind = mptc_pkg::KIND_TIMECODE; r.rate = sr_r; r.hours = sh_r;
        r.minutes = sm_r; r.seconds = ss_r; r.frames = sf_r; r.ms = tc_ms;
        r.back = (tc_ms < prev_r);
        buf_nxt[tcs_r] = r; st_nxt = ST_OUT;
      end
      ST_OUT: if (out_ready) begin
        pos_nxt = pos_r + 2'd1;
        if (pos_r == cnt_r - 2'd1) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; comp_r <= 4'd2; mode_r <= mptc_pkg::MODE_NORMAL;
      rcmd_r <= '0; rchan_r <= '0; held_r <= '0; have_r <= 1'b0; ffc_r <= '0;
      rate_r <= '0; hours_r <= '0; min_r <= '0; sec_r <= '0; frm_r <= '0;
      prev_r <= '0; lock_r <= mptc_pkg::LOCK_INVALID; cnt_r <= '0; pos_r <= '0;
    end else begin
      st_r <= st_nxt; mode_r <= mode_nxt; rcmd_r <= rcmd_nxt; rchan_r <= rchan_nxt;
      held_r <= held_nxt; have_r <= have_nxt; ffc_r <= ffc_nxt; rate_r <= rate_nxt;
      hours_r <= hours_nxt; min_r <= min_nxt; sec_r <= sec_nxt; frm_r <= frm_nxt;
      lock_r <= lock_nxt; cnt_r <= cnt_nxt; pos_r <= pos_nxt;
      if (cfg_we) comp_r <= cfg_wdata;
      if (st_r == ST_TIME && tc_done) prev_r <= tc_ms;
    end
    tcs_r <= tcs_nxt; sr_r <= sr_nxt; sh_r <= sh_nxt; sm_r <= sm_nxt;
    ss_r <= ss_nxt; sf_r <= sf_nxt; buf_r <= buf_nxt;
  end

  mptc_pkg::result_t cur;
  assign cur = buf_r[pos_r];
  assign out_valid           = (st_r == ST_OUT);
  assign out_event_kind      = cur.kind;
  assign out_channel         = cur.channel;
  assign out_data_first      = cur.data_first;
  assign out_data_second     = cur.data_second;
  assign out_frame_rate_code = cur.rate;
  assign out_tc_hours        = cur.hours;
  assign out_tc_minutes      = cur.minutes;
  assign out_tc_seconds      = cur.seconds;
  assign out_tc_frames       = cur.frames;
  assign out_time_ms         = cur.ms;
  assign out_time_went_back  = cur.back;
  assign out_last_of_run     = (pos_r == cnt_r - 2'd1);
endmodule

FILE: rtl/mptc_checker.sv
// Port-level checker for the MIDI parser, with its bind.
module mptc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_event_kind,
  input logic [4:0] out_channel,
  input logic       out_last_of_run
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind))
    else $error("result changed under stall");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input open while results pending");
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_kind <= 4'd9) else $error("bad kind");
  a_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind <= 4'd2 |-> out_channel == 5'd0)
    else $error("channel on non-channel beat");
  a_realtime_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == 4'd0 |-> out_last_of_run)
    else $error("realtime not last");
endmodule

bind midi_parser_with_timecode_top mptc_checker u_mptc_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_event_kind(out_event_kind),
  .out_channel(out_channel), .out_last_of_run(out_last_of_run)
);
